// ===== src/segx_pkg.sv =====
// Shared constants for the segment intersection pipeline.
// No dependencies.
package segx_pkg;

    // Number of register stages ahead of the pipelined restoring divider.
    localparam int FRONT_STAGES = 6;

    // Stage index names for the front-end valid vector.
    localparam int ST_DIFF = 0;
    localparam int ST_PROD = 1;
    localparam int ST_CROSS = 2;
    localparam int ST_NORM = 3;
    localparam int ST_TEST = 4;
    localparam int ST_NUM = 5;

endpackage

// ===== src/segment_intersection_top.sv =====
// Segment intersection: deep pipeline with cross products, range test and
// a one-bit-per-stage restoring divider for the intersection point.
// Depends on segx_pkg.
//
// Throughput: one beat per cycle while the output is not stalled; the divider stages set the depth.
// The whole pipeline holds while a finished beat waits at the output.
// Reset clears every valid bit; payload registers are not reset.
module segment_intersection_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] a_start_x,
    input  logic signed [COORD_WIDTH-1:0] a_start_y,
    input  logic signed [COORD_WIDTH-1:0] a_end_x,
    input  logic signed [COORD_WIDTH-1:0] a_end_y,
    input  logic signed [COORD_WIDTH-1:0] b_start_x,
    input  logic signed [COORD_WIDTH-1:0] b_start_y,
    input  logic signed [COORD_WIDTH-1:0] b_end_x,
    input  logic signed [COORD_WIDTH-1:0] b_end_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] cross_x,
    output logic signed [COORD_WIDTH-1:0] cross_y
);
    import segx_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;        // coordinate difference
    localparam int PW = 2 * W + 2;    // one cross-product term
    localparam int NW = 2 * W + 3;    // den, tn, un
    localparam int HW = NW - DW;      // upper slice of tn
    localparam int MW = NW + DW;      // divider numerator

    // Global advance: every stage moves when the output can take a beat.
    logic adv;
    logic [FRONT_STAGES-1:0] front_vld_reg;
    logic [DW-1:0] div_vld_reg;
    logic out_valid_reg;

    assign adv = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Stage 1: coordinate differences.
    logic signed [W-1:0]  s1_ax_reg, s1_ay_reg;
    logic signed [DW-1:0] s1_ex_reg, s1_ey_reg, s1_fx_reg, s1_fy_reg, s1_gx_reg, s1_gy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ax_reg <= a_start_x;
            s1_ay_reg <= a_start_y;
            s1_ex_reg <= DW'(a_start_x) - DW'(a_end_x);
            s1_ey_reg <= DW'(a_start_y) - DW'(a_end_y);
            s1_fx_reg <= DW'(b_start_x) - DW'(b_end_x);
            s1_fy_reg <= DW'(b_start_y) - DW'(b_end_y);
            s1_gx_reg <= DW'(a_start_x) - DW'(b_start_x);
            s1_gy_reg <= DW'(a_start_y) - DW'(b_start_y);
        end
    end

    // Stage 2: the six signed products.
    logic signed [W-1:0]  s2_ax_reg, s2_ay_reg;
    logic signed [DW-1:0] s2_ex_reg, s2_ey_reg;
    logic signed [PW-1:0] s2_exfy_reg, s2_eyfx_reg, s2_gxfy_reg, s2_gyfx_reg;
    logic signed [PW-1:0] s2_eygx_reg, s2_exgy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ax_reg   <= s1_ax_reg;
            s2_ay_reg   <= s1_ay_reg;
            s2_ex_reg   <= s1_ex_reg;
            s2_ey_reg   <= s1_ey_reg;
            s2_exfy_reg <= PW'(s1_ex_reg) * PW'(s1_fy_reg);
            s2_eyfx_reg <= PW'(s1_ey_reg) * PW'(s1_fx_reg);
            s2_gxfy_reg <= PW'(s1_gx_reg) * PW'(s1_fy_reg);
            s2_gyfx_reg <= PW'(s1_gy_reg) * PW'(s1_fx_reg);
            s2_eygx_reg <= PW'(s1_ey_reg) * PW'(s1_gx_reg);
            s2_exgy_reg <= PW'(s1_ex_reg) * PW'(s1_gy_reg);
        end
    end

    // Stage 3: denominator and the two numerators.
    logic signed [W-1:0]  s3_ax_reg, s3_ay_reg;
    logic signed [DW-1:0] s3_ex_reg, s3_ey_reg;
    logic signed [NW-1:0] s3_den_reg, s3_tn_reg, s3_un_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_ax_reg  <= s2_ax_reg;
            s3_ay_reg  <= s2_ay_reg;
            s3_ex_reg  <= s2_ex_reg;
            s3_ey_reg  <= s2_ey_reg;
            s3_den_reg <= NW'(s2_exfy_reg) - NW'(s2_eyfx_reg);
            s3_tn_reg  <= NW'(s2_gxfy_reg) - NW'(s2_gyfx_reg);
            s3_un_reg  <= NW'(s2_eygx_reg) - NW'(s2_exgy_reg);
        end
    end

    // Stage 4: make the denominator positive; take delta magnitudes.
    // delta = end - start = -e, so delta is negative exactly when e is positive.
    logic signed [W-1:0]  s4_ax_reg, s4_ay_reg;
    logic [DW-1:0]        s4_magx_reg, s4_magy_reg;
    logic                 s4_sx_reg, s4_sy_reg, s4_dz_reg;
    logic signed [NW-1:0] s4_den_reg, s4_tn_reg, s4_un_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_ax_reg   <= s3_ax_reg;
            s4_ay_reg   <= s3_ay_reg;
            s4_magx_reg <= s3_ex_reg[DW-1] ? -s3_ex_reg : s3_ex_reg;
            s4_magy_reg <= s3_ey_reg[DW-1] ? -s3_ey_reg : s3_ey_reg;
            s4_sx_reg   <= !s3_ex_reg[DW-1] && (s3_ex_reg != '0);
            s4_sy_reg   <= !s3_ey_reg[DW-1] && (s3_ey_reg != '0);
            s4_dz_reg   <= (s3_den_reg == '0);
            s4_den_reg  <= s3_den_reg[NW-1] ? -s3_den_reg : s3_den_reg;
            s4_tn_reg   <= s3_den_reg[NW-1] ? -s3_tn_reg : s3_tn_reg;
            s4_un_reg   <= s3_den_reg[NW-1] ? -s3_un_reg : s3_un_reg;
        end
    end

    // Stage 5: range test, and partial products of tn times delta magnitude.
    logic signed [W-1:0] s5_ax_reg, s5_ay_reg;
    logic                s5_sx_reg, s5_sy_reg, s5_hit_reg;
    logic [NW-1:0]       s5_den_reg;
    logic [2*DW-1:0]     s5_lox_reg, s5_loy_reg;
    logic [HW+DW-1:0]    s5_hix_reg, s5_hiy_reg;
    logic [DW-1:0]       s4_tn_lo;
    logic [HW-1:0]       s4_tn_hi;
    logic                s4_hit;

    assign s4_tn_lo = s4_tn_reg[DW-1:0];
    assign s4_tn_hi = s4_tn_reg[NW-1:DW];
    assign s4_hit = !s4_dz_reg && !s4_tn_reg[NW-1] && (s4_tn_reg <= s4_den_reg)
                    && !s4_un_reg[NW-1] && (s4_un_reg <= s4_den_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_ax_reg  <= s4_ax_reg;
            s5_ay_reg  <= s4_ay_reg;
            s5_sx_reg  <= s4_sx_reg;
            s5_sy_reg  <= s4_sy_reg;
            s5_hit_reg <= s4_hit;
            s5_den_reg <= s4_den_reg;
            s5_lox_reg <= (2*DW)'(s4_tn_lo) * (2*DW)'(s4_magx_reg);
            s5_loy_reg <= (2*DW)'(s4_tn_lo) * (2*DW)'(s4_magy_reg);
            s5_hix_reg <= (HW+DW)'(s4_tn_hi) * (HW+DW)'(s4_magx_reg);
            s5_hiy_reg <= (HW+DW)'(s4_tn_hi) * (HW+DW)'(s4_magy_reg);
        end
    end

    // Stage 6: assemble the full divider numerators.
    logic signed [W-1:0] s6_ax_reg, s6_ay_reg;
    logic                s6_sx_reg, s6_sy_reg, s6_hit_reg;
    logic [NW-1:0]       s6_den_reg;
    logic [MW-1:0]       s6_nx_reg, s6_ny_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_ax_reg  <= s5_ax_reg;
            s6_ay_reg  <= s5_ay_reg;
            s6_sx_reg  <= s5_sx_reg;
            s6_sy_reg  <= s5_sy_reg;
            s6_hit_reg <= s5_hit_reg;
            s6_den_reg <= s5_den_reg;
            s6_nx_reg  <= MW'(s5_lox_reg) + (MW'(s5_hix_reg) << DW);
            s6_ny_reg  <= MW'(s5_loy_reg) + (MW'(s5_hiy_reg) << DW);
        end
    end

    // Front-end valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_vld_reg <= '0;
        else if (adv)
            front_vld_reg <= {front_vld_reg[FRONT_STAGES-2:0], in_valid};
    end

    // Restoring divider: one quotient bit per stage, most significant first.
    // On a hit the quotient never exceeds the delta magnitude because tn <= den.
    logic [MW-1:0]       dv_rx_reg [DW];
    logic [MW-1:0]       dv_ry_reg [DW];
    logic [DW-1:0]       dv_qx_reg [DW];
    logic [DW-1:0]       dv_qy_reg [DW];
    logic [NW-1:0]       dv_den_reg [DW];
    logic signed [W-1:0] dv_ax_reg [DW];
    logic signed [W-1:0] dv_ay_reg [DW];
    logic [DW-1:0]       dv_sx_reg, dv_sy_reg, dv_hit_reg;

    for (genvar k = 0; k < DW; k++)
    begin : g_div
        logic [MW-1:0]       rx_in, ry_in, dsh, rx_next, ry_next;
        logic [DW-1:0]       qx_in, qy_in;
        logic [NW-1:0]       den_in;
        logic signed [W-1:0] ax_in, ay_in;
        logic                sx_in, sy_in, hit_in, vld_in, gex, gey;

        if (k == 0)
        begin : g_first
            assign rx_in  = s6_nx_reg;
            assign ry_in  = s6_ny_reg;
            assign qx_in  = '0;
            assign qy_in  = '0;
            assign den_in = s6_den_reg;
            assign ax_in  = s6_ax_reg;
            assign ay_in  = s6_ay_reg;
            assign sx_in  = s6_sx_reg;
            assign sy_in  = s6_sy_reg;
            assign hit_in = s6_hit_reg;
            assign vld_in = front_vld_reg[ST_NUM];
        end
        else
        begin : g_rest
            assign rx_in  = dv_rx_reg[k-1];
            assign ry_in  = dv_ry_reg[k-1];
            assign qx_in  = dv_qx_reg[k-1];
            assign qy_in  = dv_qy_reg[k-1];
            assign den_in = dv_den_reg[k-1];
            assign ax_in  = dv_ax_reg[k-1];
            assign ay_in  = dv_ay_reg[k-1];
            assign sx_in  = dv_sx_reg[k-1];
            assign sy_in  = dv_sy_reg[k-1];
            assign hit_in = dv_hit_reg[k-1];
            assign vld_in = div_vld_reg[k-1];
        end

        // Trial subtract of den shifted to this quotient bit.
        assign dsh = MW'(den_in) << (DW - 1 - k);
        assign gex = (rx_in >= dsh);
        assign gey = (ry_in >= dsh);
        assign rx_next = gex ? rx_in - dsh : rx_in;
        assign ry_next = gey ? ry_in - dsh : ry_in;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rx_reg[k]  <= rx_next;
                dv_ry_reg[k]  <= ry_next;
                dv_qx_reg[k]  <= {qx_in[DW-2:0], gex};
                dv_qy_reg[k]  <= {qy_in[DW-2:0], gey};
                dv_den_reg[k] <= den_in;
                dv_ax_reg[k]  <= ax_in;
                dv_ay_reg[k]  <= ay_in;
                dv_sx_reg[k]  <= sx_in;
                dv_sy_reg[k]  <= sy_in;
                dv_hit_reg[k] <= hit_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_vld_reg[k] <= 1'b0;
            else if (adv)
                div_vld_reg[k] <= vld_in;
        end
    end

    // Output stage: apply the offset sign, add the start point, gate on hit.
    logic [DW-1:0]        qx_fin, qy_fin;
    logic signed [DW:0]   offx, offy, sumx, sumy;
    logic                 hit_fin;
    logic                 hit_reg;
    logic signed [W-1:0]  cross_x_reg, cross_y_reg;

    assign qx_fin  = dv_qx_reg[DW-1];
    assign qy_fin  = dv_qy_reg[DW-1];
    assign hit_fin = dv_hit_reg[DW-1];
    assign offx = dv_sx_reg[DW-1] ? -{1'b0, qx_fin} : {1'b0, qx_fin};
    assign offy = dv_sy_reg[DW-1] ? -{1'b0, qy_fin} : {1'b0, qy_fin};
    assign sumx = (DW+1)'(dv_ax_reg[DW-1]) + offx;
    assign sumy = (DW+1)'(dv_ay_reg[DW-1]) + offy;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg     <= hit_fin;
            cross_x_reg <= hit_fin ? sumx[W-1:0] : '0;
            cross_y_reg <= hit_fin ? sumy[W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= div_vld_reg[DW-1];
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign cross_x   = cross_x_reg;
    assign cross_y   = cross_y_reg;

    // A beat that reports no hit carries a zero point.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> cross_x == '0 && cross_y == '0)
        else $error("miss beat with nonzero point");

    // While the output stalls, no stage's valid bit moves.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(front_vld_reg) && $stable(div_vld_reg))
        else $error("pipeline moved during output stall");

    // An accepted beat lands in the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> front_vld_reg[ST_DIFF])
        else $error("accepted beat lost at entry");

endmodule

// ===== test/tb_segment_intersection_top.sv =====
// Self-checking testbench for segment_intersection_top: random and directed segment pairs,
// an exact integer predictor of the hit flag and meeting point, random stalls on both sides.
// Depends on segx_pkg (latency) and the segment_intersection_top RTL.
module tb_segment_intersection_top;
    import segx_pkg::*;

    localparam int CW = 32;
    localparam int LATENCY = FRONT_STAGES + CW + 2;
    localparam int IDLE_LIMIT = 20000;
    localparam int NUM_RANDOM = 1700;

    typedef struct {
        logic signed [CW-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
        bit                   wait_drain;
    } seg_pair_t;

    typedef struct {
        logic                 hit;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } crossing_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [CW-1:0] a_start_x = '0, a_start_y = '0, a_end_x = '0, a_end_y = '0;
    logic signed [CW-1:0] b_start_x = '0, b_start_y = '0, b_end_x = '0, b_end_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit;
    logic signed [CW-1:0] cross_x, cross_y;

    seg_pair_t pending_pairs[$];
    crossing_t crossing_q[$];
    int        in_gap = 0;
    int        out_gap = 0;
    int        accepted_pairs = 0;
    int        total_pairs = 0;
    int        checked = 0;
    int        hits_seen = 0;
    int        errors = 0;
    int        idle_cycles = 0;

    segment_intersection_top #(.COORD_WIDTH(CW)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_start_x(a_start_x), .a_start_y(a_start_y),
        .a_end_x(a_end_x), .a_end_y(a_end_y),
        .b_start_x(b_start_x), .b_start_y(b_start_y),
        .b_end_x(b_end_x), .b_end_y(b_end_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .cross_x(cross_x), .cross_y(cross_y)
    );

    // Clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // One coordinate of the meeting point: start + trunc(tn * delta / den), saturated.
    function automatic logic signed [CW-1:0] point_coord(longint start, longint delta,
                                                          logic [127:0] tn, logic [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        longint       v;
        longint       hi;
        mag = (delta < 0) ? 128'(-delta) : 128'(delta);
        q = (tn * mag) / den;
        if (q > mag)
            q = mag;
        v = (delta < 0) ? start - longint'(q) : start + longint'(q);
        hi = (longint'(1) <<< (CW - 1)) - 1;
        if (v > hi)
            v = hi;
        if (v < -hi - 1)
            v = -hi - 1;
        return v[CW-1:0];
    endfunction

    // Exact cross-product intersection test on wide signed integers.
    function automatic crossing_t predict_crossing(seg_pair_t s);
        longint ax, ay, bx, by, cx, cy, dx, dy;
        logic signed [127:0] ex, ey, fx, fy, gx, gy, den, tn, un;
        crossing_t r;
        ax = s.asx; ay = s.asy; bx = s.aex; by = s.aey;
        cx = s.bsx; cy = s.bsy; dx = s.bex; dy = s.bey;
        ex = ax - bx; ey = ay - by;
        fx = cx - dx; fy = cy - dy;
        gx = ax - cx; gy = ay - cy;
        den = ex * fy - ey * fx;
        tn = gx * fy - gy * fx;
        un = ey * gx - ex * gy;
        r.hit = 1'b0;
        r.x = '0;
        r.y = '0;
        if (den == 0)
            return r;
        if (den < 0)
        begin
            den = -den;
            tn = -tn;
            un = -un;
        end
        if (tn >= 0 && tn <= den && un >= 0 && un <= den)
        begin
            r.hit = 1'b1;
            r.x = point_coord(ax, bx - ax, tn, den);
            r.y = point_coord(ay, by - ay, tn, den);
        end
        return r;
    endfunction

    // Gap length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch on beat %0d: %s got %0d expected %0d", checked, what, got, want);
    endtask

    function automatic seg_pair_t make_pair(longint asx, longint asy, longint aex, longint aey,
                                            longint bsx, longint bsy, longint bex, longint bey);
        seg_pair_t s;
        s.asx = asx[CW-1:0]; s.asy = asy[CW-1:0]; s.aex = aex[CW-1:0]; s.aey = aey[CW-1:0];
        s.bsx = bsx[CW-1:0]; s.bsy = bsy[CW-1:0]; s.bex = bex[CW-1:0]; s.bey = bey[CW-1:0];
        s.wait_drain = 1'b0;
        return s;
    endfunction

    // Coordinate with a random magnitude class, full width now and then.
    function automatic longint rand_coord(int span);
        case (span)
            0: return $signed($urandom);
            1: return $signed($urandom_range(0, 2000)) - 1000;
            2: return $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
            default: return $signed($urandom_range(0, 28'hFFFFFFF)) - 32'sh8000000;
        endcase
    endfunction

    // Pair mostly built to cross near the midpoint of A; else random, or parallel to A.
    function automatic seg_pair_t rand_pair();
        seg_pair_t s;
        int        span;
        int        kind;
        longint    asx, asy, aex, aey, mx, my, vx, vy;
        span = $urandom_range(0, 3);
        kind = $urandom_range(0, 9);
        asx = rand_coord(span); asy = rand_coord(span);
        aex = rand_coord(span); aey = rand_coord(span);
        if (kind < 3 || span == 0)
            return make_pair(asx, asy, aex, aey, rand_coord(span), rand_coord(span),
                             rand_coord(span), rand_coord(span));
        mx = (asx + aex) / 2 + ($signed($urandom_range(0, 8)) - 4);
        my = (asy + aey) / 2 + ($signed($urandom_range(0, 8)) - 4);
        vx = rand_coord(span) / 2;
        vy = rand_coord(span) / 2;
        if (kind == 9)
            s = make_pair(asx, asy, aex, aey, mx, my, mx + (aex - asx), my + (aey - asy));
        else
            s = make_pair(asx, asy, aex, aey, mx + vx, my + vy, mx - vx, my - vy);
        return s;
    endfunction

    // Driver: takes the next pair once the current beat is gone and the gap is over.
    // A pair marked to wait is held until no beat is offered and every result is back.
    always @(posedge clk)
    begin
        seg_pair_t s;
        if (rst_n && (!in_valid || in_ready))
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_pairs.size() > 0 &&
                     !(pending_pairs[0].wait_drain && (in_valid || crossing_q.size() != 0)))
            begin
                s = pending_pairs.pop_front();
                a_start_x <= s.asx; a_start_y <= s.asy; a_end_x <= s.aex; a_end_y <= s.aey;
                b_start_x <= s.bsx; b_start_y <= s.bsy; b_end_x <= s.bex; b_end_y <= s.bey;
                in_valid <= 1'b1;
                in_gap <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output back-pressure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 15)
            begin
                out_gap <= pick_gap();
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: predict on every accepted input beat, check every accepted result beat.
    always @(posedge clk)
    begin
        seg_pair_t s;
        crossing_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                s = make_pair(a_start_x, a_start_y, a_end_x, a_end_y,
                              b_start_x, b_start_y, b_end_x, b_end_y);
                crossing_q.push_back(predict_crossing(s));
                accepted_pairs++;
            end
            if (out_valid && out_ready)
            begin
                if (crossing_q.size() == 0)
                begin
                    errors++;
                    $display("result beat with no pair outstanding");
                end
                else
                begin
                    want = crossing_q.pop_front();
                    if (hit !== want.hit)
                        report_mismatch("hit", hit, want.hit);
                    if (cross_x !== want.x)
                        report_mismatch("cross_x", cross_x, want.x);
                    if (cross_y !== want.y)
                        report_mismatch("cross_y", cross_y, want.y);
                    if (want.hit)
                        hits_seen++;
                end
                checked++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("segment_intersection_top regression: fail");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        longint    mx;
        longint    mn;
        seg_pair_t s;
        mx = 64'sh7FFFFFFF;
        mn = -64'sh80000000;
        // Plain crossing, T touch at an end, shared endpoints, miss.
        pending_pairs.push_back(make_pair(0, 0, 65536, 65536, 0, 65536, 65536, 0));
        pending_pairs.push_back(make_pair(0, 0, 131072, 0, 65536, 0, 65536, 65536));
        pending_pairs.push_back(make_pair(0, 0, 65536, 0, 65536, 0, 65536, 65536));
        pending_pairs.push_back(make_pair(0, 0, 65536, 0, 0, 0, 0, -65536));
        pending_pairs.push_back(make_pair(0, 0, 65536, 65536, 200000, 0, 300000, -5));
        // Parallel, collinear overlapping, degenerate points.
        pending_pairs.push_back(make_pair(0, 0, 65536, 0, 0, 10, 65536, 10));
        pending_pairs.push_back(make_pair(0, 0, 65536, 0, 100, 0, 90000, 0));
        pending_pairs.push_back(make_pair(5, 5, 5, 5, 5, 5, 5, 5));
        pending_pairs.push_back(make_pair(0, 0, 100, 100, 50, 50, 50, 50));
        // Extremes of the coordinate range, and small segments around zero.
        pending_pairs.push_back(make_pair(mn, mn, mx, mx, mn, mx, mx, mn));
        pending_pairs.push_back(make_pair(mx, mn, mn, mx, mn, mn, mx, mx));
        pending_pairs.push_back(make_pair(mn, 0, mx, 0, 0, mn, 0, mx));
        pending_pairs.push_back(make_pair(mx, mx, mn, mn, mx, mx, mx, mn));
        pending_pairs.push_back(make_pair(mn, mn, mn, mx, mn, mn, mx, mn));
        pending_pairs.push_back(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));
        pending_pairs.push_back(make_pair(mn, mn, mx, mx - 1, mn + 1, mn, mx, mx));
        pending_pairs.push_back(make_pair(0, 0, 7, 3, 0, 3, 7, 0));
        pending_pairs.push_back(make_pair(-7, -3, 0, 0, 0, -3, -7, 0));
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            s = rand_pair();
            s.wait_drain = (i == NUM_RANDOM / 3) || (i == 2 * NUM_RANDOM / 3);
            pending_pairs.push_back(s);
        end
        total_pairs = pending_pairs.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_pairs < total_pairs || crossing_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("checked %0d result beats, %0d of them hits, under random stalls on both sides",
                 checked, hits_seen);
        if (errors == 0 && crossing_q.size() == 0)
            $display("segment_intersection_top regression: pass");
        else
            $display("segment_intersection_top regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
src/segx_pkg.sv
src/segment_intersection_top.sv
test/tb_segment_intersection_top.sv
